FILE: rtl/core/ppss_pkg.sv
// Shared constants, command codes and types for the pixel pair split scorer.
// Used by ppss_tstore, ppss_iter and pixel_pair_split_scorer; no dependencies.
`default_nettype none

package ppss_pkg;

    // Store geometry and table size.
    localparam int MAX_SAMPLES = 1024;
    localparam int MAX_DIMS    = 4;
    localparam int TOP_K       = 16;

    // Field widths.
    localparam int SI_W    = 10;
    localparam int DI_W    = 2;
    localparam int MEM_AW  = SI_W + DI_W;
    localparam int TV_W    = 16;
    localparam int PIX_W   = 16;
    localparam int PAIR_W  = 10;
    localparam int SCORE_W = 32;
    localparam int RANK_W  = 4;
    localparam int CNT_W   = 11;
    localparam int DIMS_W  = 3;
    localparam int K_W     = 5;
    localparam int SUM_W   = 28;

    // Scoring datapath widths.
    localparam int DIFF_W = SUM_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int ACC_W  = SQ_W - 8 + 2;
    localparam int RAD_W  = ACC_W + 8;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int PROD_W = CNT_W + ROOT_W;
    localparam int SACC_W = PROD_W + 1;

    // Iteration counts of the shared unit.
    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = 5;

    // Command codes carried in the input tuser.
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_EVAL = 2'd1;
    localparam logic [1:0] FUNC_EMIT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SAMPLES = 2'd0;
    localparam logic [1:0] CFG_DIMS    = 2'd1;
    localparam logic [1:0] CFG_RESULTS = 2'd2;

    // Operation of the shared unit.
    localparam logic MODE_DIV  = 1'b0;
    localparam logic MODE_SQRT = 1'b1;

    typedef struct packed {
        logic start;
        logic mode;
    } t_iter_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] result;
    } t_iter_rsp;

endpackage

`default_nettype wire

FILE: rtl/core/ppss_tstore.sv
// Target word store: one write port and one registered read port.
// Depends on ppss_pkg for address and data widths.
`default_nettype none

module ppss_tstore (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [ppss_pkg::MEM_AW-1:0] i_waddr,
    input  wire logic [ppss_pkg::TV_W-1:0]   i_wdata,
    input  wire logic [ppss_pkg::MEM_AW-1:0] i_raddr,
    output logic      [ppss_pkg::TV_W-1:0]   o_rdata
);

    logic [ppss_pkg::TV_W-1:0] r_mem [2**ppss_pkg::MEM_AW];
    logic [ppss_pkg::TV_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/ppss_iter.sv
// Shared bit-serial unit: unsigned restoring division or integer square root,
// one result bit per cycle. Depends on ppss_pkg for widths and request types.
`default_nettype none

module ppss_iter (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ppss_pkg::t_iter_req         i_req,
    input  wire logic [ppss_pkg::RAD_W-1:0]  i_num,
    input  wire logic [ppss_pkg::CNT_W-1:0]  i_den,
    output ppss_pkg::t_iter_rsp              o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic                          r_mode;
    logic [ppss_pkg::RAD_W-1:0]    r_x;
    logic [ppss_pkg::REM_W-1:0]    r_rem;
    logic [ppss_pkg::ROOT_W-1:0]   r_res;
    logic [ppss_pkg::CNT_W-1:0]    r_den;
    logic [ppss_pkg::STEP_W-1:0]   r_cnt;

    logic [ppss_pkg::REM_W-1:0]    rem_sh;
    logic [ppss_pkg::REM_W-1:0]    opb;
    logic [ppss_pkg::REM_W:0]      trial;
    logic                          ge;

    // Division brings in one dividend bit per step, the root two radicand bits.
    always_comb begin
        if (r_mode == ppss_pkg::MODE_SQRT) begin
            rem_sh = {r_rem[ppss_pkg::REM_W-3:0], r_x[ppss_pkg::RAD_W-1 -: 2]};
            opb    = {1'b0, r_res, 2'b01};
        end else begin
            rem_sh = {r_rem[ppss_pkg::REM_W-2:0], r_x[ppss_pkg::RAD_W-1]};
            opb    = {{(ppss_pkg::REM_W-ppss_pkg::CNT_W){1'b0}}, r_den};
        end
        trial = {1'b0, rem_sh} - {1'b0, opb};
        ge    = ~trial[ppss_pkg::REM_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_mode <= i_req.mode;
                r_x    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_res  <= '0;
                r_cnt  <= (i_req.mode == ppss_pkg::MODE_SQRT) ?
                          ppss_pkg::STEP_W'(ppss_pkg::SQRT_STEPS) :
                          ppss_pkg::STEP_W'(ppss_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_rem <= ge ? trial[ppss_pkg::REM_W-1:0] : rem_sh;
                r_res <= {r_res[ppss_pkg::ROOT_W-2:0], ge};
                r_x   <= (r_mode == ppss_pkg::MODE_SQRT) ? (r_x << 2) : (r_x << 1);
                r_cnt <= r_cnt - ppss_pkg::STEP_W'(1);
                if (r_cnt == ppss_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

`default_nettype wire

FILE: rtl/core/pixel_pair_split_scorer.sv
// Top level of the pixel pair split scorer: command sequencer, accumulators,
// top-K table and output register. Depends on ppss_pkg, ppss_tstore, ppss_iter.
`default_nettype none

// Usage. Commands arrive on the slave stream, one transfer per command; tuser
// selects load, evaluate or emit and tlast marks the final sample of a pair.
// A load writes one target component into the store and into the global
// totals. An evaluate reads the sample's targets, one dimension at a time,
// and adds them to the left or right side totals. On the final sample a pair
// with both sides non-empty is scored by the shared bit-serial unit: per side
// and dimension two divisions, the global and the side mean, then a square
// and add; then one square root per side and steps to weight and sum,
// followed by a table scan. An emit sorts the table by repeated selection
// scans and sends results_wanted transfers on the master stream, the final
// one with tlast. The block takes one command at a time; tready is low
// while it works. A stalled master stream holds the output register and
// stalls the emit sequence only, never losing a result. Configuration writes
// are always accepted and must be made while the block is idle. Reset clears
// the totals, counters and table; the target store keeps no reset.

module pixel_pair_split_scorer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [10:0] i_cfg_data,
    // Command stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata from bit 0: sample_index(10), dim_index(2), target_value(16),
    // pixel_first(16), pixel_second(16), pair_first(10), pair_second(10).
    input  wire logic [79:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,   // func
    input  wire logic        s_axis_tlast,   // last_sample
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata from bit 0: rank(4), best_first(10), best_second(10), score(32).
    output logic [55:0]      m_axis_tdata,
    output logic [0:0]       m_axis_tuser,   // slot_filled
    output logic             m_axis_tlast    // last
);

    localparam int SUM_W  = ppss_pkg::SUM_W;
    localparam int CNT_W  = ppss_pkg::CNT_W;
    localparam int KMAX   = ppss_pkg::TOP_K;
    localparam int IDX_W  = $clog2(ppss_pkg::TOP_K);
    localparam int NDIM   = ppss_pkg::MAX_DIMS;
    localparam int DI_IDX_W = ppss_pkg::DI_W;

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_LOAD     = 5'd1;
    localparam logic [4:0] ST_EV_RD    = 5'd2;
    localparam logic [4:0] ST_EV_ACC   = 5'd3;
    localparam logic [4:0] ST_SC_INIT  = 5'd4;
    localparam logic [4:0] ST_SC_G     = 5'd5;
    localparam logic [4:0] ST_SC_GW    = 5'd6;
    localparam logic [4:0] ST_SC_M     = 5'd7;
    localparam logic [4:0] ST_SC_MW    = 5'd8;
    localparam logic [4:0] ST_SC_SQ    = 5'd9;
    localparam logic [4:0] ST_SC_ACC   = 5'd10;
    localparam logic [4:0] ST_SC_RT    = 5'd11;
    localparam logic [4:0] ST_SC_RTW   = 5'd12;
    localparam logic [4:0] ST_SC_MUL   = 5'd13;
    localparam logic [4:0] ST_SC_SUM   = 5'd14;
    localparam logic [4:0] ST_UPD_SCAN = 5'd15;
    localparam logic [4:0] ST_UPD_WR   = 5'd16;
    localparam logic [4:0] ST_EM_SCAN  = 5'd17;
    localparam logic [4:0] ST_EM_OUT   = 5'd18;

    // Configuration registers.
    logic [CNT_W-1:0]           r_samples;
    logic [ppss_pkg::DIMS_W-1:0] r_dims;
    logic [ppss_pkg::K_W-1:0]   r_results;

    // Effective (clamped) configuration.
    logic [CNT_W-1:0]            eff_samples;
    logic [ppss_pkg::DIMS_W-1:0] eff_dims;
    logic [ppss_pkg::K_W-1:0]    eff_k;

    logic [4:0] r_state;
    logic [4:0] n_state;

    // Latched command.
    logic [ppss_pkg::SI_W-1:0]   r_si;
    logic [ppss_pkg::TV_W-1:0]   r_tval;
    logic                        r_left;
    logic                        r_last;
    logic [ppss_pkg::PAIR_W-1:0] r_pf;
    logic [ppss_pkg::PAIR_W-1:0] r_ps;

    // Accumulators.
    logic [SUM_W-1:0] r_glob [NDIM];
    logic [SUM_W-1:0] r_ltot [NDIM];
    logic [SUM_W-1:0] r_rtot [NDIM];
    logic [CNT_W-1:0] r_lcnt;
    logic [CNT_W-1:0] r_rcnt;

    // Scoring datapath.
    logic [ppss_pkg::DIMS_W-1:0] r_d;
    logic                        r_side;
    logic                        r_neg;
    logic [SUM_W-1:0]            r_g;
    logic [SUM_W-1:0]            r_m;
    logic [ppss_pkg::SQ_W-1:0]   r_sq;
    logic [ppss_pkg::ACC_W-1:0]  r_acc;
    logic [ppss_pkg::ROOT_W-1:0] r_root;
    logic [ppss_pkg::PROD_W-1:0] r_prod;
    logic [ppss_pkg::SACC_W-1:0] r_sacc;
    logic [ppss_pkg::SCORE_W-1:0] r_score;

    // Top-K table.
    logic [ppss_pkg::SCORE_W-1:0]  r_bscore [KMAX];
    logic [2*ppss_pkg::PAIR_W-1:0] r_bpair  [KMAX];
    logic [KMAX-1:0]               r_bfill;

    // Table scan state; index, selection and its score are shared by update and emit.
    logic [ppss_pkg::K_W-1:0]     r_i;
    logic [IDX_W-1:0]             r_sel;
    logic [ppss_pkg::SCORE_W-1:0] r_selv;
    logic [2*ppss_pkg::PAIR_W-1:0] r_selp;
    logic                         r_self;
    logic                         r_have;
    logic [KMAX-1:0]              r_emitted;
    logic [ppss_pkg::K_W-1:0]     r_rank;

    // Output register.
    logic        r_ovalid;
    logic [55:0] r_odata;
    logic        r_ofill;
    logic        r_olast;

    logic in_fire;
    logic out_free;
    logic d_last;
    logic rank_last;
    logic [IDX_W-1:0] scan_idx;
    logic [DI_IDX_W-1:0] d_idx;

    logic [ppss_pkg::TV_W-1:0]   mem_rdata;
    logic [ppss_pkg::MEM_AW-1:0] mem_addr;

    ppss_pkg::t_iter_req          iter_req;
    ppss_pkg::t_iter_rsp          iter_rsp;
    logic [ppss_pkg::RAD_W-1:0]   iter_num;
    logic [CNT_W-1:0]             iter_den;

    logic [SUM_W-1:0]            side_tot;
    logic [CNT_W-1:0]            side_cnt;
    logic [SUM_W-1:0]            div_src;
    logic [SUM_W-1:0]            div_mag;
    logic [SUM_W-1:0]            quot;
    logic [ppss_pkg::DIFF_W-1:0] diff;
    logic [ppss_pkg::DIFF_W-1:0] diff_mag;
    logic [ppss_pkg::SACC_W-2:0] half;
    logic [SUM_W-1:0]            rd_ext;

    // ---------------------------------------------------------------------
    // Configuration and clamping.
    // ---------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples <= CNT_W'(2);
            r_dims    <= ppss_pkg::DIMS_W'(1);
            r_results <= ppss_pkg::K_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ppss_pkg::CFG_SAMPLES: r_samples <= i_cfg_data;
                ppss_pkg::CFG_DIMS:    r_dims    <= i_cfg_data[ppss_pkg::DIMS_W-1:0];
                ppss_pkg::CFG_RESULTS: r_results <= i_cfg_data[ppss_pkg::K_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_samples < CNT_W'(2)) begin
            eff_samples = CNT_W'(2);
        end else if (r_samples > CNT_W'(ppss_pkg::MAX_SAMPLES)) begin
            eff_samples = CNT_W'(ppss_pkg::MAX_SAMPLES);
        end else begin
            eff_samples = r_samples;
        end
        if (r_dims == '0) begin
            eff_dims = ppss_pkg::DIMS_W'(1);
        end else if (r_dims > ppss_pkg::DIMS_W'(NDIM)) begin
            eff_dims = ppss_pkg::DIMS_W'(NDIM);
        end else begin
            eff_dims = r_dims;
        end
        if (r_results == '0) begin
            eff_k = ppss_pkg::K_W'(1);
        end else if (r_results > ppss_pkg::K_W'(KMAX)) begin
            eff_k = ppss_pkg::K_W'(KMAX);
        end else begin
            eff_k = r_results;
        end
    end

    // ---------------------------------------------------------------------
    // Handshakes and shared helpers.
    // ---------------------------------------------------------------------
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~r_ovalid | m_axis_tready;
    assign d_last        = ((r_d + ppss_pkg::DIMS_W'(1)) == eff_dims);
    assign rank_last     = ((r_rank + ppss_pkg::K_W'(1)) == eff_k);
    assign scan_idx      = r_i[IDX_W-1:0];
    assign d_idx         = r_d[DI_IDX_W-1:0];

    assign side_tot = r_side ? r_rtot[d_idx] : r_ltot[d_idx];
    assign side_cnt = r_side ? r_rcnt : r_lcnt;
    assign div_src  = (r_state == ST_SC_G) ? r_glob[d_idx] : side_tot;
    assign div_mag  = div_src[SUM_W-1] ? (~div_src + SUM_W'(1)) : div_src;
    assign quot     = iter_rsp.result[SUM_W-1:0];
    assign diff     = {r_m[SUM_W-1], r_m} - {r_g[SUM_W-1], r_g};
    assign diff_mag = diff[ppss_pkg::DIFF_W-1] ? (~diff + ppss_pkg::DIFF_W'(1)) : diff;
    assign half     = r_sacc[ppss_pkg::SACC_W-1:1];
    assign rd_ext   = {{(SUM_W-ppss_pkg::TV_W){mem_rdata[ppss_pkg::TV_W-1]}}, mem_rdata};

    // The shared unit divides left-aligned magnitudes and takes the root of acc<<8.
    assign iter_req.start = (r_state == ST_SC_G) | (r_state == ST_SC_M) |
                            (r_state == ST_SC_RT);
    assign iter_req.mode  = (r_state == ST_SC_RT) ? ppss_pkg::MODE_SQRT : ppss_pkg::MODE_DIV;
    assign iter_num = (r_state == ST_SC_RT) ? {r_acc, 8'h00} :
                      {div_mag, {(ppss_pkg::RAD_W-SUM_W){1'b0}}};
    assign iter_den = (r_state == ST_SC_G) ? eff_samples : side_cnt;

    assign mem_addr = {d_idx, r_si};

    ppss_tstore u_tstore (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_LOAD),
        .i_waddr (mem_addr),
        .i_wdata (r_tval),
        .i_raddr (mem_addr),
        .o_rdata (mem_rdata)
    );

    ppss_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (iter_req),
        .i_num   (iter_num),
        .i_den   (iter_den),
        .o_rsp   (iter_rsp)
    );

    // ---------------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (s_axis_tuser)
                        ppss_pkg::FUNC_LOAD: n_state = ST_LOAD;
                        ppss_pkg::FUNC_EVAL: n_state = ST_EV_RD;
                        ppss_pkg::FUNC_EMIT: n_state = ST_EM_SCAN;
                        default:             n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:    n_state = ST_IDLE;
            ST_EV_RD:   n_state = ST_EV_ACC;
            ST_EV_ACC: begin
                if (d_last) begin
                    n_state = r_last ? ST_SC_INIT : ST_IDLE;
                end else begin
                    n_state = ST_EV_RD;
                end
            end
            ST_SC_INIT: begin
                if (r_lcnt == '0 || r_rcnt == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_SC_G;
                end
            end
            ST_SC_G:    n_state = ST_SC_GW;
            ST_SC_GW:   if (iter_rsp.done) n_state = ST_SC_M;
            ST_SC_M:    n_state = ST_SC_MW;
            ST_SC_MW:   if (iter_rsp.done) n_state = ST_SC_SQ;
            ST_SC_SQ:   n_state = ST_SC_ACC;
            ST_SC_ACC:  n_state = d_last ? ST_SC_RT : ST_SC_G;
            ST_SC_RT:   n_state = ST_SC_RTW;
            ST_SC_RTW:  if (iter_rsp.done) n_state = ST_SC_MUL;
            ST_SC_MUL:  n_state = ST_SC_SUM;
            ST_SC_SUM:  n_state = r_side ? ST_UPD_SCAN : ST_SC_G;
            ST_UPD_SCAN: if (r_i == eff_k) n_state = ST_UPD_WR;
            ST_UPD_WR:  n_state = ST_IDLE;
            ST_EM_SCAN: if (r_i == eff_k) n_state = ST_EM_OUT;
            ST_EM_OUT: begin
                if (out_free) begin
                    n_state = rank_last ? ST_IDLE : ST_EM_SCAN;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------------
    // Datapath, accumulators and table.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NDIM; k++) begin
                r_glob[k] <= '0;
                r_ltot[k] <= '0;
                r_rtot[k] <= '0;
            end
            for (int k = 0; k < KMAX; k++) begin
                r_bscore[k] <= '0;
                r_bpair[k]  <= '0;
            end
            r_bfill   <= '0;
            r_lcnt    <= '0;
            r_rcnt    <= '0;
            r_d       <= '0;
            r_side    <= 1'b0;
            r_i       <= '0;
            r_have    <= 1'b0;
            r_emitted <= '0;
            r_rank    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            // A new result may replace the one leaving in the same cycle.
            if (r_state == ST_EM_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_si     <= s_axis_tdata[9:0];
                        r_d      <= (s_axis_tuser == ppss_pkg::FUNC_LOAD) ?
                                    ppss_pkg::DIMS_W'(s_axis_tdata[11:10]) : '0;
                        r_tval   <= s_axis_tdata[27:12];
                        r_left   <= (s_axis_tdata[43:28] < s_axis_tdata[59:44]);
                        r_pf     <= s_axis_tdata[69:60];
                        r_ps     <= s_axis_tdata[79:70];
                        r_last   <= s_axis_tlast;
                        r_i      <= '0;
                        r_have   <= 1'b0;
                        r_rank   <= '0;
                        r_emitted <= '0;
                    end
                end
                ST_LOAD: begin
                    r_glob[d_idx] <= r_glob[d_idx] +
                        {{(SUM_W-ppss_pkg::TV_W){r_tval[ppss_pkg::TV_W-1]}}, r_tval};
                end
                ST_EV_ACC: begin
                    if (r_left) begin
                        r_ltot[d_idx] <= r_ltot[d_idx] + rd_ext;
                    end else begin
                        r_rtot[d_idx] <= r_rtot[d_idx] + rd_ext;
                    end
                    r_d <= r_d + ppss_pkg::DIMS_W'(1);
                    if (d_last) begin
                        if (r_left) begin
                            r_lcnt <= r_lcnt + CNT_W'(1);
                        end else begin
                            r_rcnt <= r_rcnt + CNT_W'(1);
                        end
                    end
                end
                ST_SC_INIT: begin
                    r_d    <= '0;
                    r_side <= 1'b0;
                    r_acc  <= '0;
                    r_sacc <= '0;
                    // A pair with an empty side is dropped without scoring.
                    if (r_lcnt == '0 || r_rcnt == '0) begin
                        for (int k = 0; k < NDIM; k++) begin
                            r_ltot[k] <= '0;
                            r_rtot[k] <= '0;
                        end
                        r_lcnt <= '0;
                        r_rcnt <= '0;
                    end
                end
                ST_SC_G, ST_SC_M: begin
                    r_neg <= div_src[SUM_W-1];
                end
                ST_SC_GW: begin
                    if (iter_rsp.done) begin
                        r_g <= r_neg ? (~quot + SUM_W'(1)) : quot;
                    end
                end
                ST_SC_MW: begin
                    if (iter_rsp.done) begin
                        r_m <= r_neg ? (~quot + SUM_W'(1)) : quot;
                    end
                end
                ST_SC_SQ: begin
                    r_sq <= diff_mag * diff_mag;
                end
                ST_SC_ACC: begin
                    r_acc <= r_acc + ppss_pkg::ACC_W'(r_sq[ppss_pkg::SQ_W-1:8]);
                    r_d   <= r_d + ppss_pkg::DIMS_W'(1);
                end
                ST_SC_RTW: begin
                    if (iter_rsp.done) begin
                        r_root <= iter_rsp.result;
                    end
                end
                ST_SC_MUL: begin
                    r_prod <= side_cnt * r_root;
                end
                ST_SC_SUM: begin
                    r_sacc <= r_sacc + ppss_pkg::SACC_W'(r_prod);
                    if (!r_side) begin
                        r_side <= 1'b1;
                        r_d    <= '0;
                        r_acc  <= '0;
                    end else begin
                        r_i    <= ppss_pkg::K_W'(1);
                        r_sel  <= '0;
                        r_selv <= r_bscore[0];
                    end
                end
                ST_UPD_SCAN: begin
                    // Saturate the halved sum once it has settled.
                    if (|half[ppss_pkg::SACC_W-2:ppss_pkg::SCORE_W]) begin
                        r_score <= '1;
                    end else begin
                        r_score <= half[ppss_pkg::SCORE_W-1:0];
                    end
                    if (r_i != eff_k) begin
                        if (r_bscore[scan_idx] < r_selv) begin
                            r_sel  <= scan_idx;
                            r_selv <= r_bscore[scan_idx];
                        end
                        r_i <= r_i + ppss_pkg::K_W'(1);
                    end
                end
                ST_UPD_WR: begin
                    if (r_score > r_selv) begin
                        r_bscore[r_sel] <= r_score;
                        r_bpair[r_sel]  <= {r_pf, r_ps};
                        r_bfill[r_sel]  <= 1'b1;
                    end
                    for (int k = 0; k < NDIM; k++) begin
                        r_ltot[k] <= '0;
                        r_rtot[k] <= '0;
                    end
                    r_lcnt <= '0;
                    r_rcnt <= '0;
                end
                ST_EM_SCAN: begin
                    // Strictly greater keeps equal scores in slot order.
                    if (r_i != eff_k) begin
                        if (!r_emitted[scan_idx] &&
                            (!r_have || r_bscore[scan_idx] > r_selv)) begin
                            r_sel  <= scan_idx;
                            r_selv <= r_bscore[scan_idx];
                            r_selp <= r_bpair[scan_idx];
                            r_self <= r_bfill[scan_idx];
                            r_have <= 1'b1;
                        end
                        r_i <= r_i + ppss_pkg::K_W'(1);
                    end
                end
                ST_EM_OUT: begin
                    if (out_free) begin
                        r_odata  <= r_self ?
                            {r_selv, r_selp[ppss_pkg::PAIR_W-1:0],
                             r_selp[2*ppss_pkg::PAIR_W-1:ppss_pkg::PAIR_W],
                             r_rank[ppss_pkg::RANK_W-1:0]} :
                            {52'd0, r_rank[ppss_pkg::RANK_W-1:0]};
                        r_ofill  <= r_self;
                        r_olast  <= rank_last;
                        r_emitted[r_sel] <= 1'b1;
                        r_rank   <= r_rank + ppss_pkg::K_W'(1);
                        r_i      <= '0;
                        r_have   <= 1'b0;
                        if (rank_last) begin
                            for (int k = 0; k < KMAX; k++) begin
                                r_bscore[k] <= '0;
                                r_bpair[k]  <= '0;
                            end
                            r_bfill <= '0;
                            for (int k = 0; k < NDIM; k++) begin
                                r_glob[k] <= '0;
                                r_ltot[k] <= '0;
                                r_rtot[k] <= '0;
                            end
                            r_lcnt <= '0;
                            r_rcnt <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid   = r_ovalid;
    assign m_axis_tdata    = r_odata;
    assign m_axis_tuser[0] = r_ofill;
    assign m_axis_tlast    = r_olast;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    // The shared unit only finishes while the sequencer waits for it.
    a_iter_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iter_rsp.done |-> (r_state == ST_SC_GW || r_state == ST_SC_MW ||
                           r_state == ST_SC_RTW))
        else $error("shared unit finished outside a wait state");

    // The replaced slot always lies inside the kept part of the table.
    a_upd_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD_WR) |-> (ppss_pkg::K_W'(r_sel) < eff_k))
        else $error("table update slot beyond results_wanted");

    // After the final result of an emit is loaded the table is empty.
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EM_OUT && out_free && rank_last) |=>
            (r_bfill == '0 && r_lcnt == '0 && r_rcnt == '0))
        else $error("table not cleared after emit");

    // A scored pair never has an empty side.
    a_scored_sides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SC_G) |-> (r_lcnt != '0 && r_rcnt != '0))
        else $error("scoring started with an empty side");

endmodule

`default_nettype wire
